@@ src/dait_pkg.sv @@
// shared types, register codes and the period table of the divider and interval timer
// no dependencies; used by dait_core, divider_and_interval_timer, timer_checker and testbench
package dait_pkg;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register select codes
  localparam logic [1:0] SEL_DIV = 2'd0;
  localparam logic [1:0] SEL_CNT = 2'd1;
  localparam logic [1:0] SEL_MOD = 2'd2;
  localparam logic [1:0] SEL_CTL = 2'd3;

  // control register layout
  localparam int unsigned CTL_W      = 3;
  localparam int unsigned CTL_EN_BIT = 2;
  localparam int unsigned PRE_W      = 11;
  localparam int unsigned DIV_W      = 16;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  // one request as it travels from the input register to the timer core
  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
  } req_t;

  // result of one request
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
  } rsp_t;

  // prescaler period selected by control bits 1..0
  function automatic logic [PRE_W-1:0] period_of(input logic [1:0] rate);
    logic [PRE_W-1:0] p;
    case (rate)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

@@ src/dait_core.sv @@
// timer state (divider, prescaler, counter, modulo, control) and its update per request
// depends on dait_pkg
module dait_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  dait_pkg::req_t req,
  output dait_pkg::rsp_t rsp,
  output logic          timer_en
);

  logic [dait_pkg::DIV_W-1:0] div_r, div_nxt;
  logic [dait_pkg::PRE_W-1:0] pre_r, pre_nxt;
  logic [7:0]                 cnt_r, cnt_nxt;
  logic [7:0]                 mod_r, mod_nxt;
  logic [dait_pkg::CTL_W-1:0] ctl_r, ctl_nxt;

  logic [dait_pkg::PRE_W-1:0] pre_inc;
  logic                       fire;

  assign timer_en = ctl_r[dait_pkg::CTL_EN_BIT];
  assign pre_inc  = pre_r + 1'b1;
  assign fire     = pre_inc >= dait_pkg::period_of(ctl_r[1:0]);

  // next state and result for the request in flight
  always_comb begin
    div_nxt = div_r;
    pre_nxt = pre_r;
    cnt_nxt = cnt_r;
    mod_nxt = mod_r;
    ctl_nxt = ctl_r;
    rsp     = '0;
    case (req.req_type)
      dait_pkg::REQ_TICK: begin
        div_nxt = div_r + 1'b1;
        if (timer_en) begin
          pre_nxt = fire ? '0 : pre_inc;
          if (fire) begin
            if (cnt_r == dait_pkg::CNT_MAX) begin
              cnt_nxt       = mod_r;
              rsp.irq_pulse = 1'b1;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      dait_pkg::REQ_READ: begin
        unique case (req.reg_sel)
          dait_pkg::SEL_DIV: rsp.read_data = div_r[dait_pkg::DIV_W-1 -: 8];
          dait_pkg::SEL_CNT: rsp.read_data = cnt_r;
          dait_pkg::SEL_MOD: rsp.read_data = mod_r;
          default:           rsp.read_data = {{(8-dait_pkg::CTL_W){1'b0}}, ctl_r};
        endcase
      end
      dait_pkg::REQ_WRITE: begin
        unique case (req.reg_sel)
          dait_pkg::SEL_DIV: div_nxt = '0;
          dait_pkg::SEL_CNT: cnt_nxt = req.write_data;
          dait_pkg::SEL_MOD: mod_nxt = req.write_data;
          default:           ctl_nxt = req.write_data[dait_pkg::CTL_W-1:0];
        endcase
      end
      default: ;
    endcase
  end

  // state registers, updated only when the request is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
      pre_r <= '0;
      cnt_r <= '0;
      mod_r <= '0;
      ctl_r <= '0;
    end else if (go) begin
      div_r <= div_nxt;
      pre_r <= pre_nxt;
      cnt_r <= cnt_nxt;
      mod_r <= mod_nxt;
      ctl_r <= ctl_nxt;
    end
  end

endmodule

@@ src/divider_and_interval_timer.sv @@
// divider and interval timer top level: input register, timer core, result register
// depends on dait_pkg and dait_core
//
// Usage:
//   Input channel (in_valid, in_stall, in_req_type, in_reg_sel, in_write_data)
//   carries one request per transaction: a tick, a register read or a write.
//   Result channel (out_valid, out_stall, out_read_data, out_irq_pulse) returns
//   exactly one transaction per request, in order. read_data holds the
//   selected register on reads and zero otherwise; irq_pulse is set when a
//   tick overflowed the counter.
//   A request waits in the input register and passes through the timer core
//   into the result register, where it is shown until the receiver takes it.
//   Throughput is one request per cycle while out_stall does not hold; the
//   timer state updates as each request leaves the input register.
//   When out_stall holds, the result register keeps its transaction, the
//   input register fills and then in_stall rises; nothing is dropped.
//   Synchronous reset (rst_n low) empties both registers and clears the
//   divider, prescaler, counter, modulo and control registers.
module divider_and_interval_timer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [1:0] in_reg_sel,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq_pulse
);

  logic           s1_valid_r, s1_valid_nxt;
  dait_pkg::req_t s1_req_r;
  logic           out_valid_r, out_valid_nxt;
  dait_pkg::rsp_t out_rsp_r;
  dait_pkg::rsp_t core_rsp;
  logic           advance;
  logic           in_acc;
  logic           go;
  logic           timer_en;

  // pipeline moves when the result register is empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign go       = s1_valid_r && advance;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  dait_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .req      (s1_req_r),
    .rsp      (core_rsp),
    .timer_en (timer_en)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= '{req_type: in_req_type, reg_sel: in_reg_sel, write_data: in_write_data};
    end
    if (go) begin
      out_rsp_r <= core_rsp;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rsp_r.read_data;
  assign out_irq_pulse = out_rsp_r.irq_pulse;

  // an interrupt transaction never carries read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_pulse |-> out_read_data == 8'd0)
    else $error("irq transaction with nonzero read data");

  // an interrupt can only come from an enabled timer
  a_irq_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_pulse |-> timer_en)
    else $error("irq while timer disabled");

  // a held request is not lost while the result side stalls
  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("pending request dropped");

  // a stalled result stays presented
  a_hold_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_rsp_r))
    else $error("stalled result changed");

endmodule

@@ test/timer_checker.sv @@
`timescale 1ns / 100ps
// result checker for the divider and interval timer: mirrors the timer registers,
// predicts one result per accepted request and compares results in order
// depends on dait_pkg (request/result types, register codes, widths)
module timer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_reg_sel,
  input  logic [7:0]  in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  input  logic        out_irq_pulse,
  output int unsigned pending,
  output int unsigned mismatches
);
  import dait_pkg::*;

  // mirrored timer state
  logic [DIV_W-1:0] div_mirror;
  logic [PRE_W-1:0] pre_count;
  logic [7:0]       tick_count;
  logic [7:0]       reload_value;
  logic [CTL_W-1:0] ctl_bits;

  // results still owed by the block, oldest first
  rsp_t owed_results[$];

  int unsigned n_owed = 0;
  int unsigned n_bad  = 0;

  assign pending    = n_owed;
  assign mismatches = n_bad;

  // one tick: divider always runs, prescaler and counter only while enabled
  function automatic logic advance_timer();
    logic [PRE_W-1:0] period;
    logic             irq;
    irq = 1'b0;
    div_mirror = div_mirror + 1'b1;
    if (ctl_bits[CTL_EN_BIT]) begin
      case (ctl_bits[1:0])
        2'd0:    period = 11'd1024;
        2'd1:    period = 11'd16;
        2'd2:    period = 11'd64;
        default: period = 11'd256;
      endcase
      pre_count = pre_count + 1'b1;
      // a shrunk period fires at once when the prescaler is already past it
      if (pre_count >= period) begin
        pre_count = '0;
        if (tick_count == CNT_MAX) begin
          tick_count = reload_value;
          irq        = 1'b1;
        end else begin
          tick_count = tick_count + 1'b1;
        end
      end
    end
    return irq;
  endfunction

  // apply one request to the mirror and return the result it should produce
  function automatic rsp_t timer_result(input req_t r);
    rsp_t res;
    res = '0;
    case (r.req_type)
      REQ_TICK: res.irq_pulse = advance_timer();
      REQ_READ: begin
        case (r.reg_sel)
          SEL_DIV: res.read_data = div_mirror[DIV_W-1 -: 8];
          SEL_CNT: res.read_data = tick_count;
          SEL_MOD: res.read_data = reload_value;
          default: res.read_data = {{(8-CTL_W){1'b0}}, ctl_bits};
        endcase
      end
      REQ_WRITE: begin
        case (r.reg_sel)
          SEL_DIV: div_mirror   = '0;
          SEL_CNT: tick_count   = r.write_data;
          SEL_MOD: reload_value = r.write_data;
          default: ctl_bits     = r.write_data[CTL_W-1:0];
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin : watch
    req_t        req;
    rsp_t        want;
    int unsigned errs;
    errs = 0;
    if (!rst_n) begin
      div_mirror   = '0;
      pre_count    = '0;
      tick_count   = '0;
      reload_value = '0;
      ctl_bits     = '0;
      owed_results.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%02h irq_pulse=%0b", $time,
                   out_read_data, out_irq_pulse);
          errs++;
        end else begin
          want = owed_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $display("%0t: read_data expected %02h actual %02h", $time,
                     want.read_data, out_read_data);
            errs++;
          end
          if (out_irq_pulse !== want.irq_pulse) begin
            $display("%0t: irq_pulse expected %0b actual %0b", $time,
                     want.irq_pulse, out_irq_pulse);
            errs++;
          end
        end
      end
      // request transaction: predict its result
      if (in_valid && !in_stall) begin
        req.req_type   = in_req_type;
        req.reg_sel    = in_reg_sel;
        req.write_data = in_write_data;
        owed_results.push_back(timer_result(req));
      end
    end
    n_owed <= owed_results.size();
    n_bad  <= n_bad + errs;
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// top of the divider and interval timer testbench: clock, reset, request stimulus,
// receiver stalls and the verdict; depends on dait_pkg, timer_checker and the block
module testbench;
  import dait_pkg::*;

  // request type the block ignores
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int unsigned RAND_PER_PHASE = 400;
  localparam int unsigned HOLD_CYCLES    = 40;
  localparam int unsigned RUN_TICKS      = 300;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam longint     LIMIT_NS       = 5000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [1:0]  in_reg_sel;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        out_irq_pulse;
  int unsigned pending;
  int unsigned mismatches;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;

  divider_and_interval_timer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_reg_sel    (in_reg_sel),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_irq_pulse (out_irq_pulse)
  );

  timer_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_reg_sel    (in_reg_sel),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_irq_pulse (out_irq_pulse),
    .pending       (pending),
    .mismatches    (mismatches)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off to back up the pipeline
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // offer one request transaction and wait until it is taken
  task automatic issue(input logic [1:0] req, input logic [1:0] sel, input logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_req_type   <= req;
    in_reg_sel    <= sel;
    in_write_data <= data;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly ticks, counter writes pushed near overflow, control writes mostly enabled
  task automatic random_item();
    logic [1:0]  req;
    logic [1:0]  sel;
    logic [7:0]  data;
    int unsigned pick;
    pick = $urandom_range(99);
    sel  = 2'($urandom_range(3));
    data = 8'($urandom_range(255));
    if (pick < 70) begin
      req = REQ_TICK;
    end else if (pick < 82) begin
      req = REQ_READ;
    end else if (pick < 96) begin
      req = REQ_WRITE;
      if (sel == SEL_CNT && $urandom_range(1)) data = 8'($urandom_range(255, 240));
      if (sel == SEL_CTL && $urandom_range(3) != 0) begin
        data[CTL_EN_BIT] = 1'b1;
        if ($urandom_range(1)) data[1:0] = 2'd1;
      end
    end else begin
      req = REQ_NONE;
    end
    issue(req, sel, data);
  endtask

  // stimulus
  initial begin
    int unsigned i;
    int          ph;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_TICK;
    in_reg_sel    = SEL_DIV;
    in_write_data = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, control readback masking, fast overflow with reload
    issue(REQ_READ, SEL_DIV, 8'h00);
    issue(REQ_READ, SEL_CTL, 8'hFF);
    issue(REQ_WRITE, SEL_CTL, 8'hFD);
    issue(REQ_READ, SEL_CTL, 8'h00);
    issue(REQ_WRITE, SEL_MOD, 8'hFF);
    issue(REQ_WRITE, SEL_CNT, 8'hFF);
    for (i = 0; i < 16; i++) issue(REQ_TICK, SEL_CTL, 8'hFF);
    issue(REQ_NONE, SEL_CTL, 8'hFF);
    issue(REQ_WRITE, SEL_DIV, 8'h5A);
    issue(REQ_READ, SEL_DIV, 8'h00);

    // divider upper byte advances, timer running at the 256 tick period
    issue(REQ_WRITE, SEL_CTL, 8'h07);
    issue(REQ_WRITE, SEL_DIV, 8'hFF);
    for (i = 0; i < RUN_TICKS; i++) begin
      issue(REQ_TICK, 2'(i), 8'(i));
      if (i % 64 == 63) issue(REQ_READ, SEL_DIV, 8'h00);
    end
    issue(REQ_READ, SEL_DIV, 8'h00);
    issue(REQ_READ, SEL_CNT, 8'h00);

    // random traffic under different idle and stall mixes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          idle_pct  = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      repeat (RAND_PER_PHASE) random_item();
    end
    in_valid <= 1'b0;

    // drain, then give stray results time to show up
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
